>>> rtl/core/chr_pkg.sv
`timescale 1ns / 1ps
package chr_pkg;

  localparam int RING_DEPTH   = 256;
  localparam int SERVER_COUNT = 256;

  localparam int PT_W    = 32;
  localparam int OWN_W   = 8;
  localparam int ENTRY_W = PT_W + OWN_W;
  localparam int AW      = $clog2(RING_DEPTH);
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int RED_W   = ($clog2(SERVER_COUNT + 1) > OWN_W) ? $clog2(SERVER_COUNT + 1) : OWN_W;

  localparam logic [PT_W-1:0] FNV_BASIS = 32'd2166136261;
  localparam logic [PT_W-1:0] FNV_PRIME = 32'd16777619;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic            valid;
    logic [PT_W-1:0] value;
  } hash_t;

endpackage

>>> rtl/core/chr_ram.sv
`timescale 1ns / 1ps
module chr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/chr_hash.sv
`timescale 1ns / 1ps
module chr_hash (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          beat,
  input  logic [7:0]                    key_byte,
  input  logic                          last_byte,
  output chr_pkg::hash_t                hash_o
);
  import chr_pkg::*;

  logic [PT_W-1:0] acc_r, acc_nxt;
  logic [PT_W-1:0] fin_r, fin_nxt;
  logic [PT_W-1:0] s1_r, s1_nxt;
  logic [PT_W-1:0] res_r, res_nxt;
  logic            v1_r, v1_nxt;
  logic            v2_r, v2_nxt;
  logic            v3_r, v3_nxt;

  logic [PT_W-1:0] mix, folded;
  logic [PT_W-1:0] a1, a2, a3, b1, b2;

  always_comb begin
    mix    = acc_r ^ {{24{key_byte[7]}}, key_byte};
    folded = mix * FNV_PRIME;
    a1     = fin_r + (fin_r << 13);
    a2     = a1 ^ (a1 >> 7);
    a3     = a2 + (a2 << 3);
    b1     = s1_r ^ (s1_r >> 17);
    b2     = b1 + (b1 << 5);

    acc_nxt = acc_r;
    fin_nxt = fin_r;
    v1_nxt  = 1'b0;
    if (beat) begin
      if (last_byte) begin
        acc_nxt = FNV_BASIS;
        fin_nxt = folded;
        v1_nxt  = 1'b1;
      end else begin
        acc_nxt = folded;
      end
    end
    s1_nxt  = a3;
    v2_nxt  = v1_r;
    res_nxt = b2;
    v3_nxt  = v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= FNV_BASIS;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      v1_r  <= v1_nxt;
      v2_r  <= v2_nxt;
      v3_r  <= v3_nxt;
    end
    fin_r <= fin_nxt;
    s1_r  <= s1_nxt;
    res_r <= res_nxt;
  end

  assign hash_o.valid = v3_r;
  assign hash_o.value = res_r;

  ap_one_key_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> !v2_r && !v3_r)
    else $error("two keys in the finaliser at once");

  ap_acc_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> acc_r == FNV_BASIS || $past(beat))
    else $error("accumulator not returned to basis after last beat");

  ap_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |=> v2_r ##1 v3_r)
    else $error("finaliser pipeline lost a key");

endmodule

>>> rtl/core/chr_ring.sv
`timescale 1ns / 1ps
module chr_ring (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          key_end,
  input  logic                          op,
  input  logic [7:0]                    server_id,
  input  chr_pkg::hash_t                hash_i,
  output logic                          busy,
  output logic                          rd_en,
  output logic [chr_pkg::AW-1:0]        rd_addr,
  input  logic [chr_pkg::ENTRY_W-1:0]   rd_data,
  output logic                          wr_en,
  output logic [chr_pkg::AW-1:0]        wr_addr,
  output logic [chr_pkg::ENTRY_W-1:0]   wr_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [7:0]                    out_owner_id,
  output logic [31:0]                   out_key_hash
);
  import chr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_SHRD = 3'd4;
  localparam logic [2:0] S_SHWR = 3'd5;
  localparam logic [2:0] S_INS  = 3'd6;
  localparam logic [2:0] S_RES  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic             busy_r, busy_nxt;
  logic             op_r, op_nxt;
  logic [RED_W-1:0] sid_r, sid_nxt;
  logic [PT_W-1:0]  h_r, h_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] mid_r, mid_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [1:0]       st_r, st_nxt;
  logic [OWN_W-1:0] own_r, own_nxt;
  logic             ov_r, ov_nxt;
  logic [1:0]       ost_r, ost_nxt;
  logic [OWN_W-1:0] oown_r, oown_nxt;
  logic [PT_W-1:0]  ohash_r, ohash_nxt;

  logic [CNT_W-1:0] mid;
  logic [PT_W-1:0]  rd_pt;
  logic [OWN_W-1:0] rd_own;
  logic [CNT_W-1:0] idx_dec;

  assign rd_pt   = rd_data[ENTRY_W-1:OWN_W];
  assign rd_own  = rd_data[OWN_W-1:0];
  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign idx_dec = idx_r - CNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    op_nxt    = op_r;
    sid_nxt   = sid_r;
    h_nxt     = h_r;
    count_nxt = count_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    idx_nxt   = idx_r;
    st_nxt    = st_r;
    own_nxt   = own_r;
    ov_nxt    = ov_r && out_stall;
    ost_nxt   = ost_r;
    oown_nxt  = oown_r;
    ohash_nxt = ohash_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;

    if (sid_r >= RED_W'(SERVER_COUNT)) begin
      sid_nxt = sid_r - RED_W'(SERVER_COUNT);
    end
    if (key_end) begin
      busy_nxt = 1'b1;
      op_nxt   = op;
      sid_nxt  = RED_W'(server_id);
    end

    case (state_r)
      S_IDLE: begin
        if (hash_i.valid) begin
          h_nxt     = hash_i.value;
          lo_nxt    = '0;
          hi_nxt    = count_r;
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        rd_en = 1'b1;
        if (lo_r < hi_r) begin
          rd_addr   = mid[AW-1:0];
          mid_nxt   = mid;
          state_nxt = S_CMP;
        end else begin
          rd_addr   = (op_r == OP_LOOKUP && lo_r >= count_r) ? '0 : lo_r[AW-1:0];
          state_nxt = S_DEC;
        end
      end
      S_CMP: begin
        if (rd_pt < h_r) begin
          lo_nxt = mid_r + CNT_W'(1);
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_SRCH;
      end
      S_DEC: begin
        state_nxt = S_RES;
        if (op_r == OP_ADD) begin
          if (lo_r < count_r && rd_pt == h_r) begin
            st_nxt  = ST_DUP;
            own_nxt = rd_own;
          end else if (count_r == CNT_W'(RING_DEPTH)) begin
            st_nxt  = ST_FULL;
            own_nxt = '0;
          end else begin
            idx_nxt   = count_r;
            state_nxt = S_SHRD;
          end
        end else if (count_r == '0) begin
          st_nxt  = ST_EMPTY;
          own_nxt = '0;
        end else begin
          st_nxt  = ST_OK;
          own_nxt = rd_own;
        end
      end
      S_SHRD: begin
        if (idx_r > lo_r) begin
          rd_en     = 1'b1;
          rd_addr   = idx_dec[AW-1:0];
          state_nxt = S_SHWR;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_SHWR: begin
        wr_en     = 1'b1;
        wr_addr   = idx_r[AW-1:0];
        wr_data   = rd_data;
        idx_nxt   = idx_dec;
        state_nxt = S_SHRD;
      end
      S_INS: begin
        if (sid_r < RED_W'(SERVER_COUNT)) begin
          wr_en     = 1'b1;
          wr_addr   = lo_r[AW-1:0];
          wr_data   = {h_r, sid_r[OWN_W-1:0]};
          count_nxt = count_r + CNT_W'(1);
          st_nxt    = ST_OK;
          own_nxt   = sid_r[OWN_W-1:0];
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          ost_nxt   = st_r;
          oown_nxt  = own_r;
          ohash_nxt = h_r;
          busy_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
    op_r    <= op_nxt;
    sid_r   <= sid_nxt;
    h_r     <= h_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    idx_r   <= idx_nxt;
    st_r    <= st_nxt;
    own_r   <= own_nxt;
    ost_r   <= ost_nxt;
    oown_r  <= oown_nxt;
    ohash_r <= ohash_nxt;
  end

  assign busy         = busy_r;
  assign out_valid    = ov_r;
  assign out_status   = ost_r;
  assign out_owner_id = oown_r;
  assign out_key_hash = ohash_r;

  ap_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(RING_DEPTH))
    else $error("ring point count above depth");

  ap_busy_while_working: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> busy_r)
    else $error("controller working on a key while not busy");

  ap_hash_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    hash_i.valid |-> state_r == S_IDLE && busy_r)
    else $error("hash arrived while the ring was occupied");

  ap_write_in_insert: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_SHWR || state_r == S_INS) && op_r == OP_ADD)
    else $error("ring written outside an insert");

  ap_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |-> $past(state_r) == S_INS)
    else $error("point count changed outside an insert");

endmodule

>>> rtl/core/consistent_hash_ring_unit.sv
`timescale 1ns / 1ps
// Key bytes are taken one per cycle while in_stall is low; a key's last beat holds the input for the rest of the item.
// From the last beat, the key is hashed through the fin, s1 and res registers, then binary searched
// over the ring memory (one read per step), decided, and loaded into the output register once out_stall allows.
// An insert first moves each ring entry above the new point up (one read, one write), then writes the point.
// Reset clears the accumulator to the FNV basis and empties the ring; memory is not cleared.
module consistent_hash_ring_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_key_byte,
  input  logic        in_last_byte,
  input  logic [7:0]  in_server_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_owner_id,
  output logic [31:0] out_key_hash
);
  import chr_pkg::*;

  logic               busy;
  logic               beat;
  hash_t              hash;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  assign in_stall = busy;
  assign beat     = in_valid && !busy;

  chr_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (beat),
    .key_byte  (in_key_byte),
    .last_byte (in_last_byte),
    .hash_o    (hash)
  );

  chr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  chr_ring u_ring (
    .clk          (clk),
    .rst_n        (rst_n),
    .key_end      (beat && in_last_byte),
    .op           (in_op),
    .server_id    (in_server_id),
    .hash_i       (hash),
    .busy         (busy),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_owner_id (out_owner_id),
    .out_key_hash (out_key_hash)
  );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import chr_pkg::*;

  localparam int TOTAL_BEATS    = 1750;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 600;
  localparam int DIR_N          = 20;

  typedef struct packed {
    logic        op;
    logic [7:0]  key_byte;
    logic        last;
    logic [7:0]  server;
    logic        typed;
    logic [1:0]  status;
    logic [7:0]  owner;
  } beat_row_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  owner;
    logic [31:0] key_hash;
  } ring_reply_t;

  // The expected status and owner are given only where they follow directly from the
  // ring contents; every hash, and the remaining rows, come from the ring predictor.
  localparam beat_row_t DIR_ROWS [DIR_N] = '{
    '{OP_LOOKUP, 8'h00, 1'b1, 8'h00, 1'b1, ST_EMPTY, 8'h00},
    '{OP_LOOKUP, 8'hff, 1'b1, 8'hff, 1'b1, ST_EMPTY, 8'h00},
    '{OP_ADD,    8'h80, 1'b1, 8'hff, 1'b1, ST_OK,    8'hff},
    '{OP_ADD,    8'h80, 1'b1, 8'h01, 1'b1, ST_DUP,   8'hff},
    '{OP_LOOKUP, 8'h80, 1'b1, 8'h00, 1'b1, ST_OK,    8'hff},
    '{OP_LOOKUP, 8'h00, 1'b1, 8'h00, 1'b1, ST_OK,    8'hff},
    '{OP_LOOKUP, 8'h7f, 1'b0, 8'haa, 1'b0, ST_OK,    8'h00},
    '{OP_ADD,    8'h00, 1'b1, 8'h00, 1'b1, ST_OK,    8'h00},
    '{OP_ADD,    8'hff, 1'b1, 8'h55, 1'b1, ST_OK,    8'h55},
    '{OP_ADD,    8'h01, 1'b1, 8'h7f, 1'b1, ST_OK,    8'h7f},
    '{OP_LOOKUP, 8'h80, 1'b1, 8'h00, 1'b1, ST_OK,    8'hff},
    '{OP_ADD,    8'h7f, 1'b0, 8'h33, 1'b0, ST_OK,    8'h00},
    '{OP_LOOKUP, 8'h00, 1'b1, 8'hff, 1'b1, ST_OK,    8'h00},
    '{OP_LOOKUP, 8'h55, 1'b1, 8'h00, 1'b0, ST_OK,    8'h00},
    '{OP_LOOKUP, 8'haa, 1'b1, 8'h00, 1'b0, ST_OK,    8'h00},
    '{OP_ADD,    8'h12, 1'b0, 8'h00, 1'b0, ST_OK,    8'h00},
    '{OP_ADD,    8'h34, 1'b0, 8'hff, 1'b0, ST_OK,    8'h00},
    '{OP_LOOKUP, 8'h56, 1'b1, 8'h00, 1'b0, ST_OK,    8'h00},
    '{OP_ADD,    8'hff, 1'b1, 8'h00, 1'b1, ST_DUP,   8'h55},
    '{OP_ADD,    8'h56, 1'b1, 8'h80, 1'b0, ST_OK,    8'h00}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = OP_ADD;
  logic [7:0]  in_key_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic [7:0]  in_server_id = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_owner_id;
  logic [31:0] out_key_hash;

  logic [31:0] fnv_accum;
  logic [31:0] ring_pts [RING_DEPTH];
  logic [7:0]  ring_owners [RING_DEPTH];
  int unsigned ring_count;

  ring_reply_t replies_due [$];
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;

  consistent_hash_ring_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_key_byte  (in_key_byte),
    .in_last_byte (in_last_byte),
    .in_server_id (in_server_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_owner_id (out_owner_id),
    .out_key_hash (out_key_hash)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] fnv_fold(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] ext;
    ext = {{24{b[7]}}, b};
    return (acc ^ ext) * FNV_PRIME;
  endfunction

  function automatic logic [31:0] mix_hash(input logic [31:0] x);
    logic [31:0] h;
    h = x;
    h = h + (h << 13);
    h = h ^ (h >> 7);
    h = h + (h << 3);
    h = h ^ (h >> 17);
    h = h + (h << 5);
    return h;
  endfunction

  task automatic ring_predict(input beat_row_t row, output bit has_reply,
                              output ring_reply_t reply);
    logic [31:0] h;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned i;
    fnv_accum = fnv_fold(fnv_accum, row.key_byte);
    has_reply = 1'b0;
    reply = '0;
    if (row.last) begin
      has_reply = 1'b1;
      h = mix_hash(fnv_accum);
      fnv_accum = FNV_BASIS;
      lo = 0;
      hi = ring_count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (ring_pts[mid] < h) lo = mid + 1;
        else hi = mid;
      end
      reply.key_hash = h;
      if (row.op == OP_ADD) begin
        if (lo < ring_count && ring_pts[lo] == h) begin
          reply.status = ST_DUP;
          reply.owner = ring_owners[lo];
        end else if (ring_count >= RING_DEPTH) begin
          reply.status = ST_FULL;
          reply.owner = 8'h00;
        end else begin
          for (i = ring_count; i > lo; i--) begin
            ring_pts[i] = ring_pts[i-1];
            ring_owners[i] = ring_owners[i-1];
          end
          ring_pts[lo] = h;
          ring_owners[lo] = 8'(int'(row.server) % SERVER_COUNT);
          ring_count++;
          reply.status = ST_OK;
          reply.owner = ring_owners[lo];
        end
      end else if (ring_count == 0) begin
        reply.status = ST_EMPTY;
        reply.owner = 8'h00;
      end else begin
        if (lo >= ring_count) lo = 0;
        reply.status = ST_OK;
        reply.owner = ring_owners[lo];
      end
    end
  endtask

  task automatic send_key_beat(input beat_row_t row);
    bit          has_reply;
    ring_reply_t reply;
    while (!quiet && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= row.op;
    in_key_byte  <= row.key_byte;
    in_last_byte <= row.last;
    in_server_id <= row.server;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    ring_predict(row, has_reply, reply);
    if (has_reply) begin
      if (row.typed) begin
        reply.status = row.status;
        reply.owner = row.owner;
      end
      replies_due.push_back(reply);
    end
  endtask

  task automatic wait_replies_drained();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s at %0t: got %0h, expected %0h", what, $time, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 6);
    end
  end

  always @(posedge clk) begin
    ring_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected result beat", out_key_hash, 32'h0);
      end else begin
        want = replies_due.pop_front();
        if (out_status !== want.status) begin
          report_mismatch("status", 32'(out_status), 32'(want.status));
        end
        if (out_owner_id !== want.owner) begin
          report_mismatch("owner_id", 32'(out_owner_id), 32'(want.owner));
        end
        if (out_key_hash !== want.key_hash) begin
          report_mismatch("key_hash", out_key_hash, want.key_hash);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    beat_row_t   row;
    int unsigned keys_done;
    int unsigned key_len;
    int unsigned pick;
    bit          narrow;
    logic        key_op;
    logic [7:0]  key_server;
    fnv_accum = FNV_BASIS;
    ring_count = 0;
    keys_done = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_N; r++) send_key_beat(DIR_ROWS[r]);
    wait_replies_drained();

    // Narrow keys draw their bytes from a tiny alphabet, so that duplicate points and
    // exact lookup hits turn up often, including once the ring is full.
    while (beats_sent < TOTAL_BEATS) begin
      pick = $urandom_range(0, 99);
      key_len = (pick < 30) ? 1 : (pick < 60) ? 2 : (pick < 85) ? $urandom_range(3, 4) :
                $urandom_range(5, 8);
      narrow = ($urandom_range(0, 3) == 0);
      if (ring_count < RING_DEPTH) key_op = ($urandom_range(0, 9) < 7) ? OP_ADD : OP_LOOKUP;
      else key_op = ($urandom_range(0, 9) < 4) ? OP_ADD : OP_LOOKUP;
      key_server = 8'($urandom_range(0, 255));
      for (int i = 0; i < key_len; i++) begin
        row = '0;
        row.key_byte = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
        row.last = (i == key_len - 1);
        row.op = row.last ? key_op : 1'($urandom_range(0, 1));
        row.server = row.last ? key_server : 8'($urandom_range(0, 255));
        send_key_beat(row);
      end
      keys_done++;
      quiet = (keys_done >= 250 && keys_done < 450);
      if (keys_done % 150 == 0) wait_replies_drained();
    end

    wait_replies_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
